// ----- sv/cry_pkg.sv -----
package cry_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int LOG_TABLE_BITS_DEF = 8;

	localparam int ALPHA_W = 18;
	localparam int BETA_W = 18;
	localparam int SCALE_W = 17;
	localparam int COEFF_W = 17;
	localparam int DENS_W = 20;
	localparam int EPM_W = 20;
	localparam int PPM_W = 20;
	localparam int RECOMB_W = 18;
	localparam int SCINT_W = 33;
	localparam int CFG_ADDR_W = 5;
	localparam int LN_W = 38;
	localparam int LN_LAT = 5;

	localparam logic [ALPHA_W-1:0] ALPHA_RST = 18'd60948;
	localparam logic [BETA_W-1:0] BETA_RST = 18'd13894;
	localparam logic SEL_BOX_RST = 1'b1;
	localparam logic [SCALE_W-1:0] SCALE_RST = 17'd52429;
	localparam logic [COEFF_W-1:0] COEFF_RST = 17'd3185;
	localparam logic [DENS_W-1:0] DENS_RST = 20'd91095;
	localparam logic [EPM_W-1:0] EPM_RST = 20'd42373;
	localparam logic [PPM_W-1:0] PPM_RST = 20'd0;

	localparam logic [31:0] CAP32 = 32'hFFFF_FFFF;
	localparam logic [SCINT_W-1:0] CAP33 = 33'h1_FFFF_FFFF;
	localparam logic [RECOMB_W-1:0] CAP18 = 18'h3_FFFF;

	typedef enum logic [2:0] {
		REG_BOX_ALPHA   = 3'd0,
		REG_BOX_BETA    = 3'd1,
		REG_USE_BOX     = 3'd2,
		REG_BIRKS_SCALE = 3'd3,
		REG_BIRKS_COEFF = 3'd4,
		REG_DENSITY     = 3'd5,
		REG_EPM         = 3'd6,
		REG_PPM         = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic        func;
		logic [31:0] deposit_energy;
		logic [31:0] step_len;
		logic [31:0] stopping_power;
		logic [31:0] drift_field;
	} item_t;

	typedef struct packed {
		logic [31:0]         ion_electrons;
		logic [SCINT_W-1:0]  scint_photons;
		logic [RECOMB_W-1:0] recomb_factor;
		logic [31:0]         clamped_dedx;
		logic                field_error;
	} result_t;

	typedef struct packed {
		logic        func;
		logic [31:0] energy;
		logic [31:0] stopping_power;
		logic [31:0] field;
		logic        step_ok;
	} dedx_side_t;

	typedef struct packed {
		logic        func;
		logic [31:0] energy;
		logic [31:0] dedx;
		logic        field_zero;
		logic        step_ok;
	} xi_side_t;

	typedef struct packed {
		logic        func;
		logic [31:0] energy;
		logic [31:0] dedx;
		logic        field_zero;
		logic        step_ok;
		logic [31:0] xi;
		logic        s_zero;
	} ln_side_t;

	typedef struct packed {
		logic        func;
		logic [31:0] energy;
		logic [31:0] dedx;
		logic        field_zero;
		logic        force_zero;
		logic        force_cap;
	} rc_side_t;

endpackage

// ----- sv/cry_div.sv -----
module cry_div #(
	parameter int NUM_W = 48,
	parameter int DEN_W = 32,
	parameter int Q_W = 32,
	parameter type side_t = logic
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	input  side_t            side_in,
	output logic             out_valid,
	output logic [Q_W-1:0]   quo,
	output logic             ovf,
	output side_t            side_out
);

	localparam int HI_W = NUM_W - Q_W;
	localparam int CMP_W = (HI_W > DEN_W) ? HI_W : DEN_W;

	logic [Q_W:0]     valid_s;
	logic [Q_W:0]     ovf_s;
	logic [DEN_W-1:0] rem_s  [Q_W+1];
	logic [DEN_W-1:0] den_s  [Q_W+1];
	logic [Q_W-1:0]   low_s  [Q_W+1];
	logic [Q_W-1:0]   quo_s  [Q_W+1];
	side_t            side_s [Q_W+1];
	logic [HI_W-1:0]  hi;
	logic             hi_ge;

	assign hi = num[NUM_W-1:Q_W];
	assign hi_ge = CMP_W'(hi) >= CMP_W'(den);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= '0;
		end else begin
			valid_s <= {valid_s[Q_W-1:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		rem_s[0]  <= hi_ge ? '0 : DEN_W'(hi);
		den_s[0]  <= den;
		low_s[0]  <= num[Q_W-1:0];
		quo_s[0]  <= '0;
		ovf_s[0]  <= hi_ge;
		side_s[0] <= side_in;
	end

	for (genvar k = 1; k <= Q_W; k++) begin : g_step
		logic [DEN_W:0] trial;
		logic [DEN_W:0] diff;
		logic           take;

		assign trial = {rem_s[k-1], low_s[k-1][Q_W-1]};
		assign diff = trial - {1'b0, den_s[k-1]};
		assign take = trial >= {1'b0, den_s[k-1]};

		always_ff @(posedge clk) begin
			rem_s[k]  <= take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			den_s[k]  <= den_s[k-1];
			low_s[k]  <= low_s[k-1] << 1;
			quo_s[k]  <= {quo_s[k-1][Q_W-2:0], take};
			ovf_s[k]  <= ovf_s[k-1];
			side_s[k] <= side_s[k-1];
		end
	end

	assign out_valid = valid_s[Q_W];
	assign quo = quo_s[Q_W];
	assign ovf = ovf_s[Q_W];
	assign side_out = side_s[Q_W];

endmodule

// ----- sv/cry_ln.sv -----
module cry_ln #(
	parameter int FRAC_BITS = cry_pkg::FRAC_BITS_DEF,
	parameter int LOG_TABLE_BITS = cry_pkg::LOG_TABLE_BITS_DEF,
	parameter type side_t = logic
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	input  logic [32:0]                     x,
	input  side_t                           side_in,
	output logic                            out_valid,
	output logic signed [cry_pkg::LN_W-1:0] ln,
	output side_t                           side_out
);

	localparam int LTB = LOG_TABLE_BITS;
	localparam int TBL_N = (1 << LTB) + 1;
	localparam int RS = 30 - LTB;
	localparam int LW = cry_pkg::LN_W;
	localparam logic signed [LW-1:0] LN2_Q30 = 38'sd744261118;

	function automatic logic [29:0] log2_q30(input logic [63:0] y0);
		logic [63:0] y;
		logic [29:0] r;
		y = y0;
		r = '0;
		for (int b = 1; b <= 30; b++) begin
			y = (y * y) >> 30;
			if (y >= (64'd2 << 30)) begin
				y = y >> 1;
				r[30-b] = 1'b1;
			end
		end
		return r;
	endfunction

	function automatic logic [TBL_N*32-1:0] build_rom();
		logic [TBL_N*32-1:0] t;
		logic [63:0] y;
		logic [63:0] v;
		logic [63:0] prev;
		t = '0;
		prev = '0;
		for (int i = 0; i < TBL_N; i++) begin
			y = (64'd1 << 30) + (64'(i) << RS);
			v = (64'(log2_q30(y)) * 64'd2977044472) >> 32;
			if (i > 0 && v < prev) begin
				v = prev;
			end
			t[i*32 +: 32] = v[31:0];
			prev = v;
		end
		return t;
	endfunction

	localparam logic [TBL_N*32-1:0] LN_ROM = build_rom();

	logic              valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	side_t             side_s1, side_s2, side_s3, side_s4, side_s5;
	logic [32:0]       x_s1;
	logic [5:0]        p_s1, p_s2, p_s3, p_s4;
	logic [29:0]       frac_s2;
	logic [31:0]       lo_s3, dlt_s3, lo_s4, itp_s4;
	logic [RS-1:0]     rem_s3;
	logic signed [LW-1:0] ln_s5;

	logic [5:0]        p_lead;
	logic [62:0]       norm;
	logic [LTB:0]      idx_lo, idx_hi;
	logic [31:0]       rom_lo, rom_hi;
	logic [32+RS-1:0]  itp_prod;
	logic signed [6:0] expo;
	logic signed [LW-1:0] expo_ext;

	always_comb begin
		p_lead = '0;
		for (int i = 0; i < 33; i++) begin
			if (x[i]) begin
				p_lead = 6'(i);
			end
		end
	end

	assign norm = ({30'd0, x_s1} << 30) >> p_s1;
	assign idx_lo = {1'b0, frac_s2[29:RS]};
	assign idx_hi = (LTB+1)'(idx_lo + 1'b1);
	assign rom_lo = LN_ROM[{idx_lo, 5'b0} +: 32];
	assign rom_hi = LN_ROM[{idx_hi, 5'b0} +: 32];
	assign itp_prod = dlt_s3 * rem_s3;
	assign expo = $signed({1'b0, p_s4}) - 7'(FRAC_BITS);
	assign expo_ext = LW'(expo);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		x_s1    <= x;
		p_s1    <= p_lead;
		side_s1 <= side_in;
		frac_s2 <= norm[29:0];
		p_s2    <= p_s1;
		side_s2 <= side_s1;
		lo_s3   <= rom_lo;
		dlt_s3  <= rom_hi - rom_lo;
		rem_s3  <= frac_s2[RS-1:0];
		p_s3    <= p_s2;
		side_s3 <= side_s2;
		itp_s4  <= 32'(itp_prod >> RS);
		lo_s4   <= lo_s3;
		p_s4    <= p_s3;
		side_s4 <= side_s3;
		ln_s5   <= expo_ext * LN2_Q30 + LW'(lo_s4) + LW'(itp_s4);
		side_s5 <= side_s4;
	end

	assign out_valid = valid_s5;
	assign ln = ln_s5;
	assign side_out = side_s5;

endmodule

// ----- sv/charge_recombination_yield.sv -----
// Start to done runs through three one-bit-per-stage dividers and the five-stage log unit.
// Throughput: one item per cycle while busy is low; done pulses for one cycle,
// the receiver cannot stall.
// Reset: asynchronous, active low; configuration registers return to their defaults.
// busy stays high after reset and after each register write while a serial divider
// rescales the box and Birks coefficients.
module charge_recombination_yield #(
	parameter int FRAC_BITS = cry_pkg::FRAC_BITS_DEF,
	parameter int LOG_TABLE_BITS = cry_pkg::LOG_TABLE_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  cry_pkg::item_t                     item,
	output logic                               done,
	output cry_pkg::result_t                   result,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [cry_pkg::CFG_ADDR_W-1:0]     paddr,
	input  logic [31:0]                        pwdata,
	output logic [31:0]                        prdata,
	output logic                               pready
);

	localparam int F = FRAC_BITS;
	localparam int SB_W = cry_pkg::BETA_W + F;
	localparam int CNT_W = $clog2(SB_W);
	localparam int P2_W = SB_W + 32;
	localparam int LNF_W = cry_pkg::LN_W - (30 - F);
	localparam int NB_W = LNF_W + F;
	localparam int NK_W = cry_pkg::SCALE_W + F;
	localparam int NUM_C = (NB_W > NK_W) ? NB_W : NK_W;
	localparam int RW = cry_pkg::RECOMB_W;
	localparam int RE_W = RW + cry_pkg::EPM_W;
	localparam int SC_W = cry_pkg::PPM_W + 32;
	localparam int LAT = 2 * 33 + (RW + 1) + cry_pkg::LN_LAT + 8;
	localparam logic [31:0] ONE_FX = 32'd1 << F;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_LOAD = 3'b010,
		ST_CALC = 3'b100
	} state_t;

	// configuration
	logic [cry_pkg::ALPHA_W-1:0] box_alpha_q;
	logic [cry_pkg::BETA_W-1:0]  box_beta_q;
	logic                        use_box_q;
	logic [cry_pkg::SCALE_W-1:0] birks_scale_q;
	logic [cry_pkg::COEFF_W-1:0] birks_coeff_q;
	logic [cry_pkg::DENS_W-1:0]  density_q;
	logic [cry_pkg::EPM_W-1:0]   epm_q;
	logic [cry_pkg::PPM_W-1:0]   ppm_q;
	logic                        cfg_wr;
	cry_pkg::reg_idx_t           widx;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign widx = cry_pkg::reg_idx_t'(paddr[cry_pkg::CFG_ADDR_W-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_alpha_q   <= cry_pkg::ALPHA_RST;
			box_beta_q    <= cry_pkg::BETA_RST;
			use_box_q     <= cry_pkg::SEL_BOX_RST;
			birks_scale_q <= cry_pkg::SCALE_RST;
			birks_coeff_q <= cry_pkg::COEFF_RST;
			density_q     <= cry_pkg::DENS_RST;
			epm_q         <= cry_pkg::EPM_RST;
			ppm_q         <= cry_pkg::PPM_RST;
		end else if (cfg_wr) begin
			unique case (widx)
				cry_pkg::REG_BOX_ALPHA:   box_alpha_q <= pwdata[cry_pkg::ALPHA_W-1:0];
				cry_pkg::REG_BOX_BETA:    box_beta_q <= pwdata[cry_pkg::BETA_W-1:0];
				cry_pkg::REG_USE_BOX:     use_box_q <= pwdata[0];
				cry_pkg::REG_BIRKS_SCALE: birks_scale_q <= pwdata[cry_pkg::SCALE_W-1:0];
				cry_pkg::REG_BIRKS_COEFF: birks_coeff_q <= pwdata[cry_pkg::COEFF_W-1:0];
				cry_pkg::REG_DENSITY:     density_q <= pwdata[cry_pkg::DENS_W-1:0];
				cry_pkg::REG_EPM:         epm_q <= pwdata[cry_pkg::EPM_W-1:0];
				cry_pkg::REG_PPM:         ppm_q <= pwdata[cry_pkg::PPM_W-1:0];
			endcase
		end
	end

	always_comb begin
		unique case (widx)
			cry_pkg::REG_BOX_ALPHA:   prdata = 32'(box_alpha_q);
			cry_pkg::REG_BOX_BETA:    prdata = 32'(box_beta_q);
			cry_pkg::REG_USE_BOX:     prdata = 32'(use_box_q);
			cry_pkg::REG_BIRKS_SCALE: prdata = 32'(birks_scale_q);
			cry_pkg::REG_BIRKS_COEFF: prdata = 32'(birks_coeff_q);
			cry_pkg::REG_DENSITY:     prdata = 32'(density_q);
			cry_pkg::REG_EPM:         prdata = 32'(epm_q);
			cry_pkg::REG_PPM:         prdata = 32'(ppm_q);
		endcase
	end

	// coefficient rescale: B/density and k/density, one bit a cycle
	state_t                     state_q;
	logic [CNT_W-1:0]           cnt_q;
	logic [SB_W-1:0]            nb_q, nk_q, sb_q, sk_q;
	logic [cry_pkg::DENS_W-1:0] rb_q, rk_q;
	logic [cry_pkg::DENS_W-1:0] dens_eff;
	logic [cry_pkg::DENS_W:0]   tb, tk;
	logic                       take_b, take_k;

	assign dens_eff = (density_q == '0) ? cry_pkg::DENS_W'(1) : density_q;
	assign tb = {rb_q, nb_q[SB_W-1]};
	assign tk = {rk_q, nk_q[SB_W-1]};
	assign take_b = tb >= {1'b0, dens_eff};
	assign take_k = tk >= {1'b0, dens_eff};
	assign busy = state_q != ST_IDLE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			cnt_q <= '0;
		end else if (cfg_wr) begin
			state_q <= ST_LOAD;
			cnt_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: state_q <= ST_IDLE;
				ST_LOAD: begin
					state_q <= ST_CALC;
					cnt_q <= '0;
				end
				ST_CALC: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(SB_W - 1)) begin
						state_q <= ST_IDLE;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_LOAD) begin
			nb_q <= {box_beta_q, {F{1'b0}}};
			nk_q <= SB_W'({birks_coeff_q, {F{1'b0}}});
			rb_q <= '0;
			rk_q <= '0;
		end else if (state_q == ST_CALC) begin
			nb_q <= nb_q << 1;
			nk_q <= nk_q << 1;
			rb_q <= take_b ? cry_pkg::DENS_W'(tb - {1'b0, dens_eff}) : tb[cry_pkg::DENS_W-1:0];
			rk_q <= take_k ? cry_pkg::DENS_W'(tk - {1'b0, dens_eff}) : tk[cry_pkg::DENS_W-1:0];
			sb_q <= {sb_q[SB_W-2:0], take_b};
			sk_q <= {sk_q[SB_W-2:0], take_k};
		end
	end

	// dEdx = (energy << F) / step
	logic                  acc;
	cry_pkg::dedx_side_t   a_side_in, a_side;
	logic                  a_valid, a_ovf;
	logic [31:0]           a_quo;

	assign acc = start && !busy;

	always_comb begin
		a_side_in.func = item.func;
		a_side_in.energy = item.deposit_energy;
		a_side_in.stopping_power = item.stopping_power;
		a_side_in.field = item.drift_field;
		a_side_in.step_ok = item.func || (item.step_len != '0);
	end

	cry_div #(
		.NUM_W(32 + F),
		.DEN_W(32),
		.Q_W(32),
		.side_t(cry_pkg::dedx_side_t)
	) u_div_dedx (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(acc),
		.num({item.deposit_energy, {F{1'b0}}}),
		.den((item.step_len == '0) ? 32'd1 : item.step_len),
		.side_in(a_side_in),
		.out_valid(a_valid),
		.quo(a_quo),
		.ovf(a_ovf),
		.side_out(a_side)
	);

	// s1: clamp dEdx
	logic                valid_s1, valid_s2, valid_s3, valid_s4;
	logic                valid_s5, valid_s6, valid_s7, valid_s8;
	cry_pkg::xi_side_t   ctx_s1, ctx_s2, ctx_s3;
	logic [31:0]         field_s1;
	logic [31:0]         dedx_pre, dedx_clamp;

	always_comb begin
		if (a_side.func) begin
			dedx_pre = a_side.stopping_power;
		end else if (!a_side.step_ok) begin
			dedx_pre = '0;
		end else begin
			dedx_pre = a_ovf ? cry_pkg::CAP32 : a_quo;
		end
		dedx_clamp = (dedx_pre < ONE_FX) ? ONE_FX : dedx_pre;
	end

	always_ff @(posedge clk) begin
		ctx_s1.func <= a_side.func;
		ctx_s1.energy <= a_side.energy;
		ctx_s1.dedx <= dedx_clamp;
		ctx_s1.field_zero <= a_side.field == '0;
		ctx_s1.step_ok <= a_side.step_ok;
		field_s1 <= a_side.field;
	end

	// s2: scaled dEdx
	logic [SB_W-1:0] scale;
	logic [P2_W-1:0] prod2, prod2_sh;
	logic [31:0]     m_s2, fden_s2;

	assign scale = use_box_q ? sb_q : sk_q;
	assign prod2 = scale * P2_W'(ctx_s1.dedx);
	assign prod2_sh = prod2 >> F;

	always_ff @(posedge clk) begin
		m_s2 <= (prod2_sh > P2_W'(cry_pkg::CAP32)) ? cry_pkg::CAP32 : prod2_sh[31:0];
		fden_s2 <= ctx_s1.field_zero ? 32'd1 : field_s1;
		ctx_s2 <= ctx_s1;
	end

	// Xi or q = scaled / field
	logic              b_valid, b_ovf;
	logic [31:0]       b_quo;
	cry_pkg::xi_side_t b_side;

	cry_div #(
		.NUM_W(32 + F),
		.DEN_W(32),
		.Q_W(32),
		.side_t(cry_pkg::xi_side_t)
	) u_div_xi (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(valid_s2),
		.num({m_s2, {F{1'b0}}}),
		.den(fden_s2),
		.side_in(ctx_s2),
		.out_valid(b_valid),
		.quo(b_quo),
		.ovf(b_ovf),
		.side_out(b_side)
	);

	// s3: A + Xi
	logic [31:0] xi_b;
	logic [31:0] xi_s3;
	logic [32:0] sum_s3;

	assign xi_b = b_ovf ? cry_pkg::CAP32 : b_quo;

	always_ff @(posedge clk) begin
		xi_s3 <= xi_b;
		sum_s3 <= 33'(box_alpha_q) + 33'(xi_b);
		ctx_s3 <= b_side;
	end

	cry_pkg::ln_side_t                  l_side_in, l_side;
	logic                               l_valid;
	logic signed [cry_pkg::LN_W-1:0]    l_ln;

	always_comb begin
		l_side_in.func = ctx_s3.func;
		l_side_in.energy = ctx_s3.energy;
		l_side_in.dedx = ctx_s3.dedx;
		l_side_in.field_zero = ctx_s3.field_zero;
		l_side_in.step_ok = ctx_s3.step_ok;
		l_side_in.xi = xi_s3;
		l_side_in.s_zero = sum_s3 == '0;
	end

	cry_ln #(
		.FRAC_BITS(F),
		.LOG_TABLE_BITS(LOG_TABLE_BITS),
		.side_t(cry_pkg::ln_side_t)
	) u_ln (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(valid_s3),
		.x(sum_s3),
		.side_in(l_side_in),
		.out_valid(l_valid),
		.ln(l_ln),
		.side_out(l_side)
	);

	// s4: recombination divide operands
	logic [NUM_C-1:0]   numc_s4;
	logic [32:0]        denc_s4;
	cry_pkg::rc_side_t  rc_s4, rc_in;
	logic [NUM_C-1:0]   numc;
	logic [32:0]        denc;
	logic               ln_pos, xi_zero;

	assign ln_pos = l_ln > 0;
	assign xi_zero = l_side.xi == '0;

	always_comb begin
		rc_in.func = l_side.func;
		rc_in.energy = l_side.energy;
		rc_in.dedx = l_side.dedx;
		rc_in.field_zero = l_side.field_zero;
		if (use_box_q) begin
			numc = NUM_C'({l_ln[cry_pkg::LN_W-1:30-F], {F{1'b0}}});
			denc = xi_zero ? 33'd1 : {1'b0, l_side.xi};
			rc_in.force_zero = l_side.field_zero || !l_side.step_ok || l_side.s_zero || !ln_pos;
			rc_in.force_cap = xi_zero;
		end else begin
			numc = NUM_C'({birks_scale_q, {F{1'b0}}});
			denc = 33'(ONE_FX) + {1'b0, l_side.xi};
			rc_in.force_zero = l_side.field_zero;
			rc_in.force_cap = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		numc_s4 <= numc;
		denc_s4 <= denc;
		rc_s4 <= rc_in;
	end

	logic              c_valid, c_ovf;
	logic [RW-1:0]     c_quo;
	cry_pkg::rc_side_t c_side;

	cry_div #(
		.NUM_W(NUM_C),
		.DEN_W(33),
		.Q_W(RW),
		.side_t(cry_pkg::rc_side_t)
	) u_div_rc (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(valid_s4),
		.num(numc_s4),
		.den(denc_s4),
		.side_in(rc_s4),
		.out_valid(c_valid),
		.quo(c_quo),
		.ovf(c_ovf),
		.side_out(c_side)
	);

	// s5..s8: yields
	logic [RW-1:0]               recomb_s5, recomb_s6, recomb_s7;
	cry_pkg::rc_side_t           rc_s5, rc_s6, rc_s7;
	logic [RE_W-1:0]             re_s6;
	logic [cry_pkg::SCINT_W-1:0] scint_s6, scint_s7;
	logic [SC_W-1:0]             sc_prod, sc_sh;
	logic [RE_W+15:0]            plo_s7, phi_s7;
	logic [31:0]                 ion1_s7;
	logic [RE_W+31:0]            full_ion, full_sh;
	logic [31:0]                 ion0;
	cry_pkg::result_t            result_s8;

	assign sc_prod = ppm_q * rc_s5.energy;
	assign sc_sh = sc_prod >> F;
	assign full_ion = {phi_s7, 16'd0} + (RE_W+32)'(plo_s7);
	assign full_sh = full_ion >> F;
	assign ion0 = (full_sh > (RE_W+32)'(cry_pkg::CAP32)) ? cry_pkg::CAP32 : full_sh[31:0];

	always_ff @(posedge clk) begin
		if (c_side.force_zero) begin
			recomb_s5 <= '0;
		end else if (c_side.force_cap || c_ovf) begin
			recomb_s5 <= cry_pkg::CAP18;
		end else begin
			recomb_s5 <= c_quo;
		end
		rc_s5 <= c_side;

		re_s6 <= recomb_s5 * RE_W'(epm_q);
		if (rc_s5.func) begin
			scint_s6 <= cry_pkg::SCINT_W'(ppm_q);
		end else begin
			scint_s6 <= (sc_sh > SC_W'(cry_pkg::CAP33)) ? cry_pkg::CAP33 : sc_sh[cry_pkg::SCINT_W-1:0];
		end
		rc_s6 <= rc_s5;
		recomb_s6 <= recomb_s5;

		plo_s7 <= re_s6 * (RE_W+16)'(rc_s6.energy[15:0]);
		phi_s7 <= re_s6 * (RE_W+16)'(rc_s6.energy[31:16]);
		ion1_s7 <= (re_s6 > RE_W'(cry_pkg::CAP32)) ? cry_pkg::CAP32 : re_s6[31:0];
		scint_s7 <= scint_s6;
		rc_s7 <= rc_s6;
		recomb_s7 <= recomb_s6;

		result_s8.ion_electrons <= rc_s7.field_zero ? '0 : (rc_s7.func ? ion1_s7 : ion0);
		result_s8.scint_photons <= rc_s7.field_zero ? '0 : scint_s7;
		result_s8.recomb_factor <= recomb_s7;
		result_s8.clamped_dedx <= rc_s7.dedx;
		result_s8.field_error <= rc_s7.field_zero;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
			valid_s8 <= 1'b0;
		end else begin
			valid_s1 <= a_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= b_valid;
			valid_s4 <= l_valid;
			valid_s5 <= c_valid;
			valid_s6 <= valid_s5;
			valid_s7 <= valid_s6;
			valid_s8 <= valid_s7;
		end
	end

	assign done = valid_s8;
	assign result = result_s8;

`ifndef NO_ASSERTIONS
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		acc |-> ##LAT done)
		else $error("beat did not emerge after the pipeline latency");

	a_dedx_floor: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> result.clamped_dedx >= ONE_FX)
		else $error("clamped dEdx below one");

	a_field_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.field_error |-> result.ion_electrons == '0
			&& result.scint_photons == '0 && result.recomb_factor == '0)
		else $error("yields not cleared on zero field");

	a_rescale_end: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CALC && cnt_q == CNT_W'(SB_W - 1) && !cfg_wr |=> state_q == ST_IDLE)
		else $error("coefficient rescale did not finish");
`endif

endmodule

// ----- test/charge_recombination_yield_chk.sv -----
module charge_recombination_yield_chk
	import cry_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic                  busy,
	input  item_t                 item,
	input  logic                  done,
	input  result_t               result,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [31:0]           pwdata,
	input  logic                  pready,
	output int                    fails,
	output int                    pending,
	output int                    items_taken,
	output int                    beats_checked
);

	localparam longint LN2_Q30 = 744261118;
	localparam logic [63:0] LN2_Q32 = 64'd2977044472;
	localparam logic [63:0] ONE_FX = 64'd65536;
	localparam int RS = 30 - LOG_TABLE_BITS_DEF;
	localparam int ROM_N = (1 << LOG_TABLE_BITS_DEF) + 1;

	logic [31:0] ln_rom [ROM_N];
	logic [ALPHA_W-1:0] cfg_alpha;
	logic [BETA_W-1:0]  cfg_beta;
	logic               cfg_box;
	logic [SCALE_W-1:0] cfg_scale;
	logic [COEFF_W-1:0] cfg_coeff;
	logic [DENS_W-1:0]  cfg_dens;
	logic [EPM_W-1:0]   cfg_epm;
	logic [PPM_W-1:0]   cfg_ppm;
	result_t            yield_queue [$];

	function automatic logic [63:0] log2_frac(logic [63:0] y);
		logic [63:0] r;
		r = 0;
		for (int b = 1; b <= 30; b++) begin
			y = (y * y) >> 30;
			if (y >= (64'd2 << 30)) begin
				y = y >> 1;
				r = r | (64'd1 << (30 - b));
			end
		end
		return r;
	endfunction

	initial begin
		logic [63:0] v;
		for (int i = 0; i < ROM_N; i++) begin
			v = (log2_frac((64'd1 << 30) + (64'(i) << RS)) * LN2_Q32) >> 32;
			if (i > 0 && v < 64'(ln_rom[i-1]))
				v = 64'(ln_rom[i-1]);
			ln_rom[i] = v[31:0];
		end
	end

	function automatic logic [63:0] mul_clip(logic [63:0] a, logic [63:0] b, int sh,
			logic [63:0] cap);
		logic [127:0] p;
		p = (128'(a) * 128'(b)) >> sh;
		return (p > 128'(cap)) ? cap : p[63:0];
	endfunction

	function automatic logic [63:0] div_clip(logic [63:0] a, logic [63:0] d);
		logic [63:0] q;
		q = (a << 16) / d;
		return (q > 64'(CAP32)) ? 64'(CAP32) : q;
	endfunction

	function automatic longint ln_fix(logic [63:0] x);
		int p;
		logic [63:0] frac, idx, rem, lo, hi, lnm;
		p = 0;
		while (p < 63 && (x >> (p + 1)) != 0)
			p++;
		if (p <= 30)
			frac = (x << (30 - p)) - (64'd1 << 30);
		else
			frac = (x >> (p - 30)) - (64'd1 << 30);
		idx = frac >> RS;
		rem = frac & ((64'd1 << RS) - 1);
		lo = 64'(ln_rom[idx]);
		hi = 64'(ln_rom[idx + 1]);
		lnm = lo + (((hi - lo) * rem) >> RS);
		return longint'(p - 16) * LN2_Q30 + longint'(lnm);
	endfunction

	function automatic result_t predict_yield(item_t it);
		result_t r;
		logic [63:0] dens, dedx, rec, ion, scint, sb, xi, s, q, lnf;
		logic ok;
		longint l;
		dens = (cfg_dens != 0) ? 64'(cfg_dens) : 64'd1;
		ok = 1'b1;
		rec = 0;
		ion = 0;
		scint = 0;
		if (!it.func) begin
			if (it.step_len == 0) begin
				dedx = 0;
				ok = 1'b0;
			end else begin
				dedx = (64'(it.deposit_energy) << 16) / 64'(it.step_len);
				if (dedx > 64'(CAP32))
					dedx = 64'(CAP32);
			end
		end else begin
			dedx = 64'(it.stopping_power);
		end
		if (dedx < ONE_FX)
			dedx = ONE_FX;
		if (it.drift_field != 0) begin
			if (cfg_box) begin
				if (ok) begin
					sb = (64'(cfg_beta) << 16) / dens;
					xi = div_clip(mul_clip(sb, dedx, 16, 64'(CAP32)), 64'(it.drift_field));
					s = 64'(cfg_alpha) + xi;
					if (s != 0) begin
						l = ln_fix(s);
						if (l > 0) begin
							if (xi == 0) begin
								rec = 64'(CAP18);
							end else begin
								lnf = 64'(l) >> 14;
								rec = (lnf << 16) / xi;
							end
						end
					end
				end
			end else begin
				sb = (64'(cfg_coeff) << 16) / dens;
				q = div_clip(mul_clip(sb, dedx, 16, 64'(CAP32)), 64'(it.drift_field));
				rec = (64'(cfg_scale) << 16) / (ONE_FX + q);
			end
			if (rec > 64'(CAP18))
				rec = 64'(CAP18);
			if (!it.func) begin
				ion = mul_clip(rec * 64'(cfg_epm), 64'(it.deposit_energy), 16, 64'(CAP32));
				scint = mul_clip(64'(cfg_ppm), 64'(it.deposit_energy), 16, 64'(CAP33));
			end else begin
				ion = rec * 64'(cfg_epm);
				if (ion > 64'(CAP32))
					ion = 64'(CAP32);
				scint = 64'(cfg_ppm);
			end
		end
		r.ion_electrons = ion[31:0];
		r.scint_photons = scint[SCINT_W-1:0];
		r.recomb_factor = rec[RECOMB_W-1:0];
		r.clamped_dedx = dedx[31:0];
		r.field_error = (it.drift_field == 0);
		return r;
	endfunction

	task automatic report(string what, logic [63:0] got, logic [63:0] want);
		$display("mismatch %s: got %0h, want %0h (beat %0d)", what, got, want, beats_checked);
		fails++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_alpha <= ALPHA_RST;
			cfg_beta <= BETA_RST;
			cfg_box <= SEL_BOX_RST;
			cfg_scale <= SCALE_RST;
			cfg_coeff <= COEFF_RST;
			cfg_dens <= DENS_RST;
			cfg_epm <= EPM_RST;
			cfg_ppm <= PPM_RST;
		end else if (psel && penable && pwrite && pready) begin
			case (reg_idx_t'(paddr[4:2]))
				REG_BOX_ALPHA: cfg_alpha <= pwdata[ALPHA_W-1:0];
				REG_BOX_BETA: cfg_beta <= pwdata[BETA_W-1:0];
				REG_USE_BOX: cfg_box <= pwdata[0];
				REG_BIRKS_SCALE: cfg_scale <= pwdata[SCALE_W-1:0];
				REG_BIRKS_COEFF: cfg_coeff <= pwdata[COEFF_W-1:0];
				REG_DENSITY: cfg_dens <= pwdata[DENS_W-1:0];
				REG_EPM: cfg_epm <= pwdata[EPM_W-1:0];
				REG_PPM: cfg_ppm <= pwdata[PPM_W-1:0];
				default: ;
			endcase
		end
	end

	initial begin
		fails = 0;
		pending = 0;
		items_taken = 0;
		beats_checked = 0;
	end

	always @(posedge clk) begin
		result_t want;
		if (arst_n) begin
			if (start && !busy) begin
				yield_queue.push_back(predict_yield(item));
				items_taken++;
			end
			if (done) begin
				if (yield_queue.size() == 0) begin
					report("unexpected beat", 64'(result.ion_electrons), 0);
				end else begin
					want = yield_queue.pop_front();
					if (result.ion_electrons !== want.ion_electrons)
						report("ion_electrons", 64'(result.ion_electrons), 64'(want.ion_electrons));
					if (result.scint_photons !== want.scint_photons)
						report("scint_photons", 64'(result.scint_photons), 64'(want.scint_photons));
					if (result.recomb_factor !== want.recomb_factor)
						report("recomb_factor", 64'(result.recomb_factor), 64'(want.recomb_factor));
					if (result.clamped_dedx !== want.clamped_dedx)
						report("clamped_dedx", 64'(result.clamped_dedx), 64'(want.clamped_dedx));
					if (result.field_error !== want.field_error)
						report("field_error", 64'(result.field_error), 64'(want.field_error));
				end
				beats_checked++;
			end
			pending <= yield_queue.size();
		end
	end

endmodule

// ----- test/charge_recombination_yield_tb.sv -----
module charge_recombination_yield_tb;
	import cry_pkg::*;

	localparam int CYCLE_LIMIT = 600000;

	logic                  clk;
	logic                  arst_n;
	logic                  start;
	logic                  busy;
	item_t                 item;
	logic                  done;
	result_t               result;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [CFG_ADDR_W-1:0] paddr;
	logic [31:0]           pwdata;
	logic [31:0]           prdata;
	logic                  pready;
	int                    fails;
	int                    pending;
	int                    items_taken;
	int                    beats_checked;
	int                    cycles;
	bit                    steady;

	charge_recombination_yield DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item(item),
		.done(done), .result(result), .psel(psel), .penable(penable),
		.pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
		.pready(pready)
	);

	charge_recombination_yield_chk u_chk (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item(item),
		.done(done), .result(result), .psel(psel), .penable(penable),
		.pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .pready(pready),
		.fails(fails), .pending(pending), .items_taken(items_taken),
		.beats_checked(beats_checked)
	);

	initial clk = 1'b0;
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	task automatic write_reg(reg_idx_t idx, logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic load_regs(logic [31:0] a, logic [31:0] b, logic [31:0] box,
			logic [31:0] sc, logic [31:0] k, logic [31:0] d, logic [31:0] e,
			logic [31:0] p);
		write_reg(REG_BOX_ALPHA, a);
		write_reg(REG_BOX_BETA, b);
		write_reg(REG_USE_BOX, box);
		write_reg(REG_BIRKS_SCALE, sc);
		write_reg(REG_BIRKS_COEFF, k);
		write_reg(REG_DENSITY, d);
		write_reg(REG_EPM, e);
		write_reg(REG_PPM, p);
	endtask

	task automatic send(item_t it);
		int gap;
		bit taken;
		if ($urandom_range(0, 49) == 0)
			steady = !steady;
		gap = steady ? 0 : $urandom_range(0, 18);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		item <= it;
		forever begin
			@(negedge clk);
			taken = !busy;
			@(posedge clk);
			if (taken)
				break;
		end
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (110) @(posedge clk);
	endtask

	function automatic logic [31:0] pick_word();
		case ($urandom_range(0, 5))
			0: return 32'h0;
			1: return 32'hFFFF_FFFF;
			2: return $urandom_range(0, 32'h0004_0000);
			3: return $urandom_range(32'h0001_0000, 32'h0100_0000);
			default: return $urandom;
		endcase
	endfunction

	function automatic item_t rand_deposit();
		item_t it;
		it.func = 1'($urandom_range(0, 1));
		it.deposit_energy = pick_word();
		it.step_len = ($urandom_range(0, 15) == 0) ? 32'h0 : pick_word();
		it.stopping_power = pick_word();
		it.drift_field = ($urandom_range(0, 15) == 0) ? 32'h0 :
			($urandom_range(0, 1) ? $urandom : $urandom_range(1, 32'h0100_0000));
		return it;
	endfunction

	function automatic item_t mk(logic f, logic [31:0] e, logic [31:0] s,
			logic [31:0] sp, logic [31:0] fl);
		item_t it;
		it.func = f;
		it.deposit_energy = e;
		it.step_len = s;
		it.stopping_power = sp;
		it.drift_field = fl;
		return it;
	endfunction

	task automatic run_random(int n);
		repeat (n) send(rand_deposit());
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		cycles = 0;
		steady = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send(mk(1'b0, 32'h0002_0000, 32'h0001_0000, 32'h0, 32'h0005_0000));
		send(mk(1'b1, 32'h0, 32'h0, 32'h0003_8000, 32'h0005_0000));
		send(mk(1'b0, 32'h0004_0000, 32'h0, 32'h0, 32'h0005_0000));
		send(mk(1'b0, 32'h0004_0000, 32'h0002_0000, 32'h0, 32'h0));
		send(mk(1'b1, 32'h0, 32'h0, 32'h0, 32'h0));
		send(mk(1'b1, 32'h0, 32'h0, 32'h0000_8000, 32'h0001_0000));
		send(mk(1'b0, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0, 32'h0000_0001));
		send(mk(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
		send(mk(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF));
		send(mk(1'b0, 32'h0, 32'h0001_0000, 32'hFFFF_FFFF, 32'h0001_0000));
		send(mk(1'b1, 32'h0, 32'h0, 32'hFFFF_FFFF, 32'h0000_0001));
		send(mk(1'b0, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0, 32'h0000_0001));
		drain();
		run_random(220);

		load_regs(32'h3FFFF, 32'h3FFFF, 1, 32'h1FFFF, 32'h1FFFF, 32'hFFFFF,
			32'hFFFFF, 32'hFFFFF);
		run_random(200);
		load_regs(60948, 13894, 0, 52429, 3185, 91095, 42373, 30000);
		run_random(200);
		load_regs(0, 0, 1, 0, 0, 0, 1, 1);
		run_random(150);
		load_regs(32'h20000, 0, 1, 32'h1FFFF, 0, 1, 32'hFFFFF, 0);
		run_random(150);
		load_regs(32'h3FFFF, 32'h3FFFF, 0, 32'h1FFFF, 32'h1FFFF, 1, 32'hFFFFF,
			32'hFFFFF);
		run_random(150);
		repeat (4) begin
			load_regs($urandom, $urandom, $urandom, $urandom, $urandom,
				$urandom, $urandom, $urandom);
			run_random(170);
		end

		$display("%0d deposits sent over 10 register settings, box and Birks, both paths",
			items_taken);
		$display("%0d result beats compared field by field, %0d failures",
			beats_checked, fails);
		if (fails == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
